FILE: hdl/windowed_detection_statistics_macros.svh
// assertion macros for the windowed detection statistics block
`ifndef WINDOWED_DETECTION_STATISTICS_MACROS_SVH
`define WINDOWED_DETECTION_STATISTICS_MACROS_SVH
// property holds at every clock edge while out of reset
`define WDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// implication with the consequent checked in the cycle after the antecedent
`define WDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/wds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_pkg
// shared constants for the windowed detection statistics block
// ----------------------------------------------------------------------------
package wds_pkg;
    localparam int unsigned DEFAULT_DEPTH = 256;
    localparam logic [15:0] KEEP_RESET   = 16'd60;
    localparam logic [15:0] WINDOW_RESET = 16'd30;
    localparam logic [15:0] RATIO_RESET  = 16'd3277;
    localparam logic [1:0]  REG_KEEP   = 2'd0;
    localparam logic [1:0]  REG_WINDOW = 2'd1;
    localparam logic [1:0]  REG_RATIO  = 2'd2;
    localparam logic [1:0]  REG_SPARE  = 2'd3;
    localparam logic        OP_ADD    = 1'b0;
    localparam logic        OP_REPORT = 1'b1;
    // tdata layout widths
    localparam int unsigned S_TDATA_W = 152;
    localparam int unsigned M_TDATA_W = 240;
    // record word: time, flags, player conf, npc conf, proc time, pts
    localparam int unsigned REC_W = 32 + 2 + 16 + 16 + 20 + 64;
endpackage

FILE: hdl/wds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module wds_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hdl/windowed_detection_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_detection_statistics
// ring of detection records with windowed statistics per item
// ----------------------------------------------------------------------------
// each word on an add has its record written, then the single-port record
// ram is walked from the oldest end to drop stale records (one read plus one
// compare per record, stopping at the first kept one, at the latest the new
// record itself); the kept records are walked once more for the window
// statistics; first and last pts are read in ST_FIRST_RD, ST_LAST_RD and
// ST_LAST_GET; then one shared restoring divider runs three divisions (player
// ratio, npc ratio, mean proc time) of CW+20 steps each. the block takes no
// input word while a word is at work; the result sits in an output register
// and is held until taken.
module windowed_detection_statistics #(
    parameter int unsigned DEPTH = wds_pkg::DEFAULT_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: now_ms, has player, has_npc, player_conf, npc_conf,
    //          proc_time_us, pts
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wds_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: op
    input  logic [0:0]                   s_tuser,
    // m_tdata: player_seen, npc_seen, window_count, player ratio, npc_ratio,
    //          player_max_conf, npc_max_conf, avg_proc_time_us, first_pts,
    //          last_pts, stored_count, save_segment
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [wds_pkg::M_TDATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data
);
    import wds_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    // proc time sum and divider width
    localparam int unsigned SW = CW + 20;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRITE, ST_DROP_RD, ST_DROP_CHK, ST_WIN_RD, ST_WIN_ACC,
        ST_FIRST_RD, ST_LAST_RD, ST_LAST_GET, ST_DIV, ST_DONE, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_PLAYER, DIV_NPC, DIV_PROC
    } div_sel_t;

    state_t state_reg;
    logic [15:0] keep_reg, window_reg, ratio_min_reg;
    logic [AW-1:0] oldest_reg;
    logic [CW-1:0] held_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0] now_reg;
    logic [REC_W-1:0] rec_in_reg;
    logic [32:0] cut_reg;
    logic [CW-1:0] total_reg, pcnt_reg, ncnt_reg;
    logic [15:0] pmax_reg, nmax_reg;
    logic [SW-1:0] sum_reg;
    logic [63:0] first_reg, last_reg;
    // divider
    div_sel_t    div_sel_reg;
    logic [5:0]  div_step_reg;
    logic [SW-1:0] num_reg;
    logic [SW-1:0] quo_reg;
    logic [SW-1:0] rem_reg;
    logic [15:0] pratio_reg, nratio_reg;
    logic [M_TDATA_W-1:0] out_reg;

    // ram
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [REC_W-1:0] ram_rdata;

    wds_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_rec_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (rec_in_reg),
        .rdata (ram_rdata)
    );

    // slot of record idx in ring order
    function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                             input logic [CW-1:0] i);
        logic [CW:0] s;
        s = {1'b0, {(CW-AW){1'b0}}, base} + {1'b0, i};
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // cutoff now - secs*1000 clamped at zero, 33 bits with bit 32 unused
    function automatic logic [32:0] cut_f(input logic [31:0] now,
                                          input logic [15:0] secs);
        logic [33:0] span;
        span = 34'(secs) * 34'd1000;
        return (34'(now) > span) ? 33'(34'(now) - span) : 33'd0;
    endfunction

    // dividend of each division: counts scaled to Q1.15, or the proc sum
    function automatic logic [SW-1:0] num_f(input div_sel_t sel,
                                            input logic [CW-1:0] pc,
                                            input logic [CW-1:0] nc,
                                            input logic [SW-1:0] sum);
        case (sel)
            DIV_PLAYER: num_f = {5'd0, pc, 15'd0};
            DIV_NPC:    num_f = {5'd0, nc, 15'd0};
            default:    num_f = sum;
        endcase
    endfunction

    // record fields
    logic [31:0] rd_time;
    logic [1:0]  rd_flags;
    logic [15:0] rd_pconf, rd_nconf;
    logic [19:0] rd_proc;
    logic [63:0] rd_pts;
    assign {rd_pts, rd_proc, rd_nconf, rd_pconf, rd_flags, rd_time} = ram_rdata;

    always_comb begin
        ram_we   = (state_reg == ST_WRITE);
        ram_addr = slot_f(oldest_reg, idx_reg);
    end

    // a configuration write goes first when both are offered
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = out_reg;

    // divider trial subtraction, msb is the borrow
    logic [SW-1:0] div_den;
    logic [SW+1:0] trial;
    always_comb begin
        div_den = SW'(total_reg);
        trial = {1'b0, rem_reg, num_reg[SW-1]} - {2'b0, div_den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            keep_reg      <= KEEP_RESET;
            window_reg    <= WINDOW_RESET;
            ratio_min_reg <= RATIO_RESET;
            oldest_reg    <= '0;
            held_reg      <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        case (cfg_index)
                            REG_KEEP:   keep_reg      <= cfg_data;
                            REG_WINDOW: window_reg    <= cfg_data;
                            REG_RATIO:  ratio_min_reg <= cfg_data;
                            default: ;
                        endcase
                    end else if (s_tvalid) begin
                        now_reg    <= s_tdata[31:0];
                        // tdata below the pad is laid out as the record word
                        rec_in_reg <= s_tdata[REC_W-1:0];
                        if (s_tuser[0] == OP_ADD) begin
                            if (held_reg >= CW'(DEPTH)) begin
                                oldest_reg <= slot_f(oldest_reg, CW'(1));
                                held_reg   <= held_reg - 1'b1;
                                idx_reg    <= held_reg - 1'b1;
                            end else begin
                                idx_reg <= held_reg;
                            end
                            state_reg <= ST_WRITE;
                        end else begin
                            idx_reg   <= '0;
                            cut_reg   <= cut_f(s_tdata[31:0], window_reg);
                            state_reg <= ST_WIN_RD;
                        end
                        total_reg <= '0; pcnt_reg <= '0; ncnt_reg <= '0;
                        pmax_reg  <= '0; nmax_reg <= '0; sum_reg  <= '0;
                    end
                end
                ST_WRITE: begin
                    held_reg <= held_reg + 1'b1;
                    idx_reg  <= '0;
                    if (held_reg + 1'b1 >= CW'(2)) begin
                        cut_reg   <= cut_f(now_reg, keep_reg);
                        state_reg <= ST_DROP_RD;
                    end else begin
                        cut_reg   <= cut_f(now_reg, window_reg);
                        state_reg <= ST_WIN_RD;
                    end
                end
                ST_DROP_RD: begin
                    if (idx_reg == held_reg) begin
                        // no record kept: nothing dropped
                        idx_reg   <= '0;
                        cut_reg   <= cut_f(now_reg, window_reg);
                        state_reg <= ST_WIN_RD;
                    end else begin
                        state_reg <= ST_DROP_CHK;
                    end
                end
                ST_DROP_CHK: begin
                    if (33'(rd_time) >= cut_reg) begin
                        oldest_reg <= ram_addr;
                        held_reg   <= held_reg - idx_reg;
                        idx_reg    <= '0;
                        cut_reg    <= cut_f(now_reg, window_reg);
                        state_reg  <= ST_WIN_RD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_DROP_RD;
                    end
                end
                ST_WIN_RD: begin
                    if (idx_reg == held_reg) begin
                        idx_reg   <= '0;
                        state_reg <= ST_FIRST_RD;
                    end else begin
                        state_reg <= ST_WIN_ACC;
                    end
                end
                ST_WIN_ACC: begin
                    if (33'(rd_time) >= cut_reg) begin
                        total_reg <= total_reg + 1'b1;
                        sum_reg   <= sum_reg + SW'(rd_proc);
                        if (rd_flags[0]) begin
                            pcnt_reg <= pcnt_reg + 1'b1;
                            if (rd_pconf > pmax_reg) pmax_reg <= rd_pconf;
                        end
                        if (rd_flags[1]) begin
                            ncnt_reg <= ncnt_reg + 1'b1;
                            if (rd_nconf > nmax_reg) nmax_reg <= rd_nconf;
                        end
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_WIN_RD;
                end
                ST_FIRST_RD: begin
                    // ram address now points at the oldest record
                    idx_reg   <= held_reg - 1'b1;
                    state_reg <= ST_LAST_RD;
                end
                ST_LAST_RD: begin
                    first_reg <= (held_reg != '0) ? rd_pts : 64'd0;
                    state_reg <= ST_LAST_GET;
                end
                ST_LAST_GET: begin
                    last_reg     <= (held_reg != '0) ? rd_pts : 64'd0;
                    div_sel_reg  <= DIV_PLAYER;
                    num_reg      <= num_f(DIV_PLAYER, pcnt_reg, ncnt_reg, sum_reg);
                    div_step_reg <= '0;
                    rem_reg      <= '0;
                    quo_reg      <= '0;
                    state_reg    <= ST_DIV;
                end
                ST_DIV: begin
                    // one restoring step per cycle, dividend shifted out msb first
                    if (!trial[SW+1]) begin
                        rem_reg <= trial[SW-1:0];
                        quo_reg <= {quo_reg[SW-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[SW-2:0], num_reg[SW-1]};
                        quo_reg <= {quo_reg[SW-2:0], 1'b0};
                    end
                    num_reg <= {num_reg[SW-2:0], 1'b0};
                    if (div_step_reg == 6'(SW - 1)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        div_step_reg <= div_step_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    case (div_sel_reg)
                        DIV_PLAYER: pratio_reg <= (total_reg != '0) ? quo_reg[15:0] : 16'd0;
                        DIV_NPC:    nratio_reg <= (total_reg != '0) ? quo_reg[15:0] : 16'd0;
                        default: ;
                    endcase
                    div_step_reg <= '0;
                    rem_reg      <= '0;
                    quo_reg      <= '0;
                    if (div_sel_reg == DIV_PROC) begin
                        state_reg <= ST_OUT;
                        out_reg <= {7'd0,
                            (pcnt_reg != '0) && (pratio_reg >= ratio_min_reg),
                            9'(held_reg), last_reg, first_reg,
                            (total_reg != '0) ? quo_reg[19:0] : 20'd0,
                            nmax_reg, pmax_reg, nratio_reg, pratio_reg,
                            9'(total_reg), ncnt_reg != '0, pcnt_reg != '0};
                    end else if (div_sel_reg == DIV_PLAYER) begin
                        div_sel_reg <= DIV_NPC;
                        num_reg     <= num_f(DIV_NPC, pcnt_reg, ncnt_reg, sum_reg);
                        state_reg   <= ST_DIV;
                    end else begin
                        div_sel_reg <= DIV_PROC;
                        num_reg     <= num_f(DIV_PROC, pcnt_reg, ncnt_reg, sum_reg);
                        state_reg   <= ST_DIV;
                    end
                end
                ST_OUT: begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`include "windowed_detection_statistics_macros.svh"

    `WDS_ASSERT(a_one_side, !(m_tvalid && s_tready), "input taken while result pending")
    `WDS_ASSERT(a_held_max, held_reg <= CW'(DEPTH), "ring count beyond depth")
    `WDS_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "not busy after accept")
endmodule

FILE: tb/windowed_detection_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_detection_statistics_tb
// self-checking bench: each input word goes through a behavioral model of the
// record ring and the windowed statistics, and every result word is compared
// field by field in order. Directed checks cover the corner cases. Random
// phases then run under several register settings, with random stalls on
// both streams.
// ----------------------------------------------------------------------------
module windowed_detection_statistics_tb;
    import wds_pkg::*;

    localparam int unsigned RING    = 256;
    localparam int unsigned LATENCY = 2 * RING + 100;   // settle wait used by drain after the last result

    typedef struct {
        logic        op;
        logic [31:0] now_ms;
        logic        player_flag;
        logic        has_npc;
        logic [15:0] player_conf;
        logic [15:0] npc_conf;
        logic [19:0] proc_us;
        logic [63:0] pts;
    } detection_t;

    typedef struct {
        logic        player_seen;
        logic        npc_seen;
        logic [8:0]  window_count;
        logic [15:0] player_share;
        logic [15:0] npc_ratio;
        logic [15:0] player_max;
        logic [15:0] npc_max;
        logic [19:0] avg_proc;
        logic [63:0] first_pts;
        logic [63:0] last_pts;
        logic [8:0]  stored_count;
        logic        save_segment;
    } stats_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_KEEP;
    logic [15:0] cfg_data = '0;

    // model copy of the ring and the registers
    logic [31:0] ring_time [RING];
    logic [1:0]  ring_flags [RING];
    logic [15:0] ring_pconf [RING];
    logic [15:0] ring_nconf [RING];
    logic [19:0] ring_proc [RING];
    logic [63:0] ring_pts [RING];
    int unsigned ring_head = 0;
    int unsigned ring_held = 0;
    logic [15:0] keep_s = KEEP_RESET;
    logic [15:0] window_s = WINDOW_RESET;
    logic [15:0] min_ratio = RATIO_RESET;

    stats_t      expected_stats [$];
    int unsigned mismatches = 0;
    bit          hold_off_req = 1'b0;
    logic [31:0] clock_ms = 32'd0;

    windowed_detection_statistics i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #60000000;
        $display("windowed_detection_statistics_tb NOT OK");
        $finish;
    end

    function automatic logic [63:0] cutoff(logic [31:0] now, logic [15:0] secs);
        logic [63:0] span;
        span = {48'd0, secs} * 64'd1000;
        return ({32'd0, now} > span) ? {32'd0, now} - span : 64'd0;
    endfunction

    // updates the model ring and returns the statistics for one word
    function automatic stats_t window_stats(detection_t d);
        stats_t r;
        int unsigned slot, i, total, pcnt, ncnt;
        logic [63:0] cut, sum, pr, nr;
        r = '{default: '0};
        total = 0; pcnt = 0; ncnt = 0; sum = 0; pr = 0; nr = 0;
        if (d.op == OP_ADD) begin
            if (ring_held >= RING) begin
                ring_head = (ring_head + 1) % RING;
                ring_held--;
            end
            slot = (ring_head + ring_held) % RING;
            ring_time[slot]  = d.now_ms;
            ring_flags[slot] = {d.has_npc, d.player_flag};
            ring_pconf[slot] = d.player_conf;
            ring_nconf[slot] = d.npc_conf;
            ring_proc[slot]  = d.proc_us;
            ring_pts[slot]   = d.pts;
            ring_held++;
            if (ring_held >= 2) begin
                // drop stale records from the oldest end, only if one is kept
                cut = cutoff(d.now_ms, keep_s);
                for (i = 0; i < ring_held; i++)
                    if ({32'd0, ring_time[(ring_head + i) % RING]} >= cut) break;
                if (i < ring_held) begin
                    ring_head = (ring_head + i) % RING;
                    ring_held -= i;
                end
            end
        end
        cut = cutoff(d.now_ms, window_s);
        for (i = 0; i < ring_held; i++) begin
            slot = (ring_head + i) % RING;
            if ({32'd0, ring_time[slot]} < cut) continue;
            total++;
            sum += 64'(ring_proc[slot]);
            if (ring_flags[slot][0]) begin
                pcnt++;
                if (ring_pconf[slot] > r.player_max) r.player_max = ring_pconf[slot];
            end
            if (ring_flags[slot][1]) begin
                ncnt++;
                if (ring_nconf[slot] > r.npc_max) r.npc_max = ring_nconf[slot];
            end
        end
        if (total > 0) begin
            pr = (64'(pcnt) * 64'd32768) / 64'(total);
            nr = (64'(ncnt) * 64'd32768) / 64'(total);
            r.avg_proc = 20'(sum / 64'(total));
        end
        r.player_seen  = pcnt > 0;
        r.npc_seen     = ncnt > 0;
        r.window_count = 9'(total);
        r.player_share = pr[15:0];
        r.npc_ratio    = nr[15:0];
        r.first_pts    = (ring_held != 0) ? ring_pts[ring_head] : 64'd0;
        r.last_pts     = (ring_held != 0) ? ring_pts[(ring_head + ring_held - 1) % RING]
                                          : 64'd0;
        r.stored_count = 9'(ring_held);
        r.save_segment = r.player_seen && (pr[15:0] >= min_ratio);
        return r;
    endfunction

    // sends one word with a random gap; expectation is queued at offer time
    task automatic send_word(detection_t d);
        int unsigned gap;
        stats_t e;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        e = window_stats(d);
        expected_stats.insert(expected_stats.size(), e);
        s_tvalid <= 1'b1;
        s_tuser  <= d.op;
        s_tdata  <= S_TDATA_W'({d.pts, d.proc_us, d.npc_conf, d.player_conf, d.has_npc,
                                d.player_flag, d.now_ms});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic detection_word(logic op, logic [31:0] now, logic [63:0] pts);
        detection_t d;
        d.op = op; d.now_ms = now; d.pts = pts;
        d.player_flag = 1'($urandom_range(0, 1));
        d.has_npc = 1'($urandom_range(0, 1));
        d.player_conf = 16'($urandom);
        d.npc_conf = 16'($urandom);
        d.proc_us = 20'($urandom);
        send_word(d);
    endtask

    // waits until every result has come back and the block is idle again
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_stats.size() > 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEEP:   keep_s = value;
            REG_WINDOW: window_s = value;
            REG_RATIO:  min_ratio = value;
            default: ;  // unused index is ignored
        endcase
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] keep, logic [15:0] win, logic [15:0] ratio);
        drain();
        write_reg(REG_KEEP, keep);
        write_reg(REG_WINDOW, win);
        write_reg(REG_RATIO, ratio);
    endtask

    // empty ring, extreme fields, clamped cutoffs, ratio extremes
    task automatic test_directed();
        detection_t d;
        detection_word(OP_REPORT, 32'd0, 64'd0);          // report on empty ring
        d = '{op: OP_ADD, now_ms: 32'd0, player_flag: 1'b1, has_npc: 1'b1,
              player_conf: 16'hFFFF, npc_conf: 16'hFFFF, proc_us: 20'hFFFFF,
              pts: 64'h7FFF_FFFF_FFFF_FFFF};
        send_word(d);
        d = '{op: OP_ADD, now_ms: 32'd5, player_flag: 1'b0, has_npc: 1'b0,
              player_conf: 16'h0, npc_conf: 16'h0, proc_us: 20'h0,
              pts: 64'h8000_0000_0000_0000};
        send_word(d);
        detection_word(OP_ADD, 32'd29_000, 64'd3);
        detection_word(OP_REPORT, 32'd40_000, 64'd0);     // window leaves old records out
        detection_word(OP_ADD, 32'd200_000, 64'hFFFF_FFFF_FFFF_FFFF); // all stale dropped
        set_regs(16'd1, 16'd0, 16'd0);
        detection_word(OP_ADD, 32'd200_000, 64'd7);
        detection_word(OP_ADD, 32'd200_999, 64'd8);
        detection_word(OP_ADD, 32'd201_500, 64'd9);
        detection_word(OP_REPORT, 32'd201_500, 64'd0);
        set_regs(16'hFFFF, 16'hFFFF, 16'd32768);
        write_reg(REG_SPARE, 16'hFFFF);                   // unused index
        for (int i = 0; i < 4; i++)
            detection_word(OP_ADD, 32'hFFFF_FF00 + i, 64'($urandom));
        d = '{op: OP_ADD, now_ms: 32'hFFFF_FFFF, player_flag: 1'b1, has_npc: 1'b0,
              player_conf: 16'h8000, npc_conf: 16'h1, proc_us: 20'd1, pts: 64'd1};
        send_word(d);
        detection_word(OP_ADD, 32'd1000, 64'd2);          // time going backwards
        detection_word(OP_REPORT, 32'hFFFF_FFFF, 64'd0);
        drain();
    endtask

    // sends RING + 6 words, about one in eight a report, to fill the ring toward its depth
    task automatic test_ring_full();
        set_regs(16'hFFFF, 16'hFFFF, RATIO_RESET);
        for (int i = 0; i < RING + 6; i++)
            detection_word($urandom_range(0, 7) == 0, 32'd1000 + i * 3, {$urandom, $urandom});
        drain();
    endtask

    // receiver stalls for a long stretch while words keep coming
    task automatic test_back_pressure();
        set_regs(16'd60, 16'd30, RATIO_RESET);
        hold_off_req = 1'b1;
        for (int i = 0; i < 8; i++)
            detection_word(OP_ADD, 32'd5000 + i * 100, 64'($urandom));
        drain();
    endtask

    // random traffic with mostly monotonic time and some noise
    task automatic test_random_phase(int unsigned words);
        logic [31:0] step;
        for (int i = 0; i < words; i++) begin
            case ($urandom_range(0, 19))
                0:       clock_ms = $urandom;                       // jump anywhere
                1:       clock_ms = clock_ms - $urandom_range(0, 5000);
                default: begin
                    step = $urandom_range(0, 3000);
                    clock_ms = (clock_ms > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF
                                                                 : clock_ms + step;
                end
            endcase
            detection_word($urandom_range(0, 4) == 0, clock_ms, {$urandom, $urandom});
        end
    endtask

    // result receiver with random stalls and one long hold-off on request
    initial begin
        int unsigned n;
        @(posedge aresetn);
        forever begin
            n = $urandom_range(0, 9);
            if (hold_off_req) begin
                n = 3000;
                hold_off_req = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                n = 0;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act) begin
            $error("%s expected %0h got %0h", name, exp, act);
            mismatches++;
        end
    endtask

    // compares every accepted result word with the oldest expectation
    always @(posedge aclk) begin
        logic [239:0] w;
        stats_t e;
        if (aresetn && m_tvalid && m_tready) begin
            w = '0;
            w[M_TDATA_W-1:0] = m_tdata;
            if (expected_stats.size() == 0) begin
                $error("result word with no expectation pending");
                mismatches++;
            end else begin
                e = expected_stats.pop_front();
                check_field("player_seen", 64'(e.player_seen), 64'(w[0]));
                check_field("npc_seen", 64'(e.npc_seen), 64'(w[1]));
                check_field("window_count", 64'(e.window_count), 64'(w[10:2]));
                check_field("player ratio", 64'(e.player_share), 64'(w[26:11]));
                check_field("npc_ratio", 64'(e.npc_ratio), 64'(w[42:27]));
                check_field("player_max_conf", 64'(e.player_max), 64'(w[58:43]));
                check_field("npc_max_conf", 64'(e.npc_max), 64'(w[74:59]));
                check_field("avg_proc_time_us", 64'(e.avg_proc), 64'(w[94:75]));
                check_field("first_pts", e.first_pts, w[158:95]);
                check_field("last_pts", e.last_pts, w[222:159]);
                check_field("stored_count", 64'(e.stored_count), 64'(w[231:223]));
                check_field("save_segment", 64'(e.save_segment), 64'(w[232]));
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_ring_full();
        test_back_pressure();
        set_regs(KEEP_RESET, WINDOW_RESET, RATIO_RESET);
        test_random_phase(400);
        set_regs(16'd5, 16'd2, 16'd16384);
        test_random_phase(300);
        set_regs(16'd600, 16'd300, 16'd0);
        test_random_phase(300);
        set_regs(16'd1, 16'd0, 16'd32768);
        test_random_phase(300);
        set_regs(16'd65535, 16'd65535, 16'd8000);
        clock_ms = 32'hFFF0_0000;
        test_random_phase(300);
        drain();
        if (mismatches == 0)
            $display("windowed_detection_statistics_tb OK");
        else
            $display("windowed_detection_statistics_tb NOT OK");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/wds_pkg.sv
hdl/wds_ram.sv
hdl/windowed_detection_statistics.sv
tb/windowed_detection_statistics_tb.sv
